// File: sv/mst_pkg.sv
// Package for the memory self-test sequencer: codes, phase type, result word
// type and small helper functions. No dependencies.
package mst_pkg;

  localparam int ADDR_BITS_DEFAULT = 16;
  localparam int OUT_ADDR_W = 16;
  localparam int OFF_W = 17;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [7:0] PAT_A = 8'hAA;
  localparam logic [7:0] PAT_5 = 8'h55;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_ACK   = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } rsp_kind_t;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_DONE  = 2'd2,
    REQ_NONE  = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    CFG_BASE = 2'd0,
    CFG_SIZE = 2'd1,
    CFG_TEST = 2'd2,
    CFG_NONE = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    TEST_DATA_BUS = 2'd0,
    TEST_ADDR_BUS = 2'd1,
    TEST_DEVICE   = 2'd2,
    TEST_NONE     = 2'd3
  } test_sel_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_D_WR     = 4'd1,
    PH_D_RD     = 4'd2,
    PH_A_FILL   = 4'd3,
    PH_A_BASE55 = 4'd4,
    PH_A_HIGH   = 4'd5,
    PH_A_BASEAA = 4'd6,
    PH_A_T55    = 4'd7,
    PH_A_TBASE  = 4'd8,
    PH_A_TRD    = 4'd9,
    PH_A_TAA    = 4'd10,
    PH_V_WR1    = 4'd11,
    PH_V_RD1    = 4'd12,
    PH_V_WR2    = 4'd13,
    PH_V_RD2    = 4'd14
  } phase_t;

  typedef struct packed {
    logic [1:0]            request_kind;
    logic [OUT_ADDR_W-1:0] access_address;
    logic [7:0]            write_data;
    logic                  failed;
    logic [OUT_ADDR_W-1:0] fail_info;
  } result_t;

  function automatic logic is_read_phase(input phase_t p);
    return (p == PH_D_RD) || (p == PH_A_HIGH) || (p == PH_A_TBASE) ||
           (p == PH_A_TRD) || (p == PH_V_RD1) || (p == PH_V_RD2);
  endfunction

  function automatic logic [OFF_W-1:0] dbl(input logic [OFF_W-1:0] off);
    return {off[OFF_W-2:0], 1'b0};
  endfunction

  // base + offset, wrapped by the address mask and cut to the output width
  function automatic logic [OUT_ADDR_W-1:0] addr_of(input logic [OUT_ADDR_W-1:0] base,
                                                    input logic [OFF_W-1:0] off,
                                                    input logic [OUT_ADDR_W-1:0] amask);
    logic [OFF_W:0] sum;
    sum = {2'b00, base} + {1'b0, off};
    return sum[OUT_ADDR_W-1:0] & amask;
  endfunction

endpackage

// File: sv/mst_rsp_if.sv
// Response channel: memory responses and start commands into the sequencer.
// Depends on mst_pkg.
interface mst_rsp_if
  import mst_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] read_data;

  modport source (output valid, kind, read_data, input ready);
  modport sink (input valid, kind, read_data, output ready);
endinterface

// File: sv/mst_req_if.sv
// Request channel: memory requests and done words out of the sequencer.
// Depends on mst_pkg.
interface mst_req_if
  import mst_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [1:0]            request_kind;
  logic [OUT_ADDR_W-1:0] access_address;
  logic [7:0]            write_data;
  logic                  failed;
  logic [OUT_ADDR_W-1:0] fail_info;

  modport source (output valid, request_kind, access_address, write_data, failed, fail_info,
                  input ready);
  modport sink (input valid, request_kind, access_address, write_data, failed, fail_info,
                output ready);
endinterface

// File: sv/memory_self_test_sequencer.sv
// Top level of the memory self-test sequencer: input register, core, output register.
// Uses mst_pkg, mst_rsp_if, mst_req_if, mst_core and mst_out_buf.
//
// Usage: write base_address, region_size and test_select on the cfg port
// (cfg_we, cfg_index, cfg_data) while the block is idle. Send a start word
// (kind 0) on rsp; the block answers on req with a write request or a done word.
// Each write acknowledge (kind 1) or read byte (kind 2) sent back on rsp
// yields the next request, or a done word (request_kind 2) with failed and
// fail_info. Start while a test runs and responses that match no outstanding
// request produce no word.
// A request word passes the input register, then the core, which loads the result
// register, and can be taken from there. One word per cycle is sustained while req
// does not stall; in use the memory round trip sets the pace.
// Reset clears both registers and returns the test to idle with the default
// configuration. When req stalls, the result register holds its word and the
// input register takes one more word, after which rsp.ready drops.
module memory_self_test_sequencer
  import mst_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mst_rsp_if.sink               rsp,
  mst_req_if.source             req
);

  logic       in_valid;
  logic [1:0] in_kind;
  logic [7:0] in_data;
  logic       fire;
  logic       can_load;
  logic       emit;
  result_t    result;

  assign fire      = in_valid && can_load;
  assign rsp.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rsp.ready) begin
      in_valid <= rsp.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.ready && rsp.valid) begin
      in_kind <= rsp.kind;
      in_data <= rsp.read_data;
    end
  end

  mst_core #(
    .ADDR_BITS(ADDR_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .kind      (in_kind),
    .read_data (in_data),
    .emit      (emit),
    .result    (result)
  );

  mst_out_buf u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (fire && emit),
    .result   (result),
    .can_load (can_load),
    .req      (req)
  );

  a_done_no_access: assert property (@(posedge clk) disable iff (rst)
    (req.valid && (req.request_kind == REQ_DONE)) |->
      (req.access_address == '0) && (req.write_data == '0))
    else $error("done word carries an access");

  a_fail_only_done: assert property (@(posedge clk) disable iff (rst)
    (req.valid && (req.request_kind != REQ_DONE)) |-> !req.failed)
    else $error("fail flag on a request word");

  a_accept_held: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.ready) |=> in_valid)
    else $error("accepted word lost in input register");

endmodule

// File: sv/mst_core.sv
// Sequencer core: configuration registers, test state and the one-pass step
// logic that turns a response word into the next request word. Uses mst_pkg.
module mst_core
  import mst_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  fire,
  input  logic [1:0]            kind,
  input  logic [7:0]            read_data,
  output logic                  emit,
  output result_t               result
);

  localparam int ADDR_KEEP = (ADDR_BITS < OUT_ADDR_W) ? ADDR_BITS : OUT_ADDR_W;
  localparam logic [OUT_ADDR_W:0] AMASK_W = ({{OUT_ADDR_W{1'b0}}, 1'b1} << ADDR_KEEP) - 1'b1;
  localparam logic [OUT_ADDR_W-1:0] AMASK = AMASK_W[OUT_ADDR_W-1:0];

  logic [OUT_ADDR_W-1:0] base_address;
  logic [OFF_W-1:0]      region_size;
  logic [1:0]            test_select;

  phase_t           phase, phase_next;
  logic [7:0]       pattern_reg, pattern_next;
  logic [OFF_W-1:0] offset_reg, offset_next;
  logic [OFF_W-1:0] probe_offset, probe_next;

  logic [OFF_W-1:0] mask;
  logic [OFF_W-1:0] offset_inc;
  logic             dev_more;
  logic [7:0]       pv_old, pv_new;
  logic             issue, done, fail, fail_pat;
  logic [OFF_W-1:0] fail_off;
  logic             rd_kind, rsp_ok;
  logic [OFF_W-1:0] req_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      region_size  <= {1'b1, {(OFF_W-1){1'b0}}};
      test_select  <= TEST_DATA_BUS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE: base_address <= cfg_data[OUT_ADDR_W-1:0];
        CFG_SIZE: region_size <= cfg_data[OFF_W-1:0];
        CFG_TEST: test_select <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      pattern_reg  <= '0;
      offset_reg   <= '0;
      probe_offset <= '0;
    end else if (fire) begin
      phase        <= phase_next;
      pattern_reg  <= pattern_next;
      offset_reg   <= offset_next;
      probe_offset <= probe_next;
    end
  end

  assign mask       = (region_size == '0) ? '0 : region_size - 1'b1;
  assign offset_inc = offset_reg + 1'b1;
  assign dev_more   = offset_inc < region_size;
  assign pv_old     = offset_reg[7:0] + 8'd1;
  assign rd_kind    = (kind == KIND_READ);
  assign rsp_ok     = ((kind == KIND_ACK) || rd_kind) && (phase != PH_IDLE) &&
                      (rd_kind == is_read_phase(phase));

  // next state
  always_comb begin
    phase_next   = phase;
    pattern_next = pattern_reg;
    offset_next  = offset_reg;
    probe_next   = probe_offset;
    issue        = 1'b0;
    done         = 1'b0;
    fail         = 1'b0;
    fail_pat     = 1'b0;
    fail_off     = '0;
    if (kind == KIND_START) begin
      if (phase == PH_IDLE) begin
        unique case (test_select)
          TEST_DATA_BUS: begin
            pattern_next = 8'd1;
            phase_next   = PH_D_WR;
            issue        = 1'b1;
          end
          TEST_ADDR_BUS: begin
            offset_next = {{(OFF_W-1){1'b0}}, 1'b1};
            phase_next  = mask[0] ? PH_A_FILL : PH_A_BASE55;
            issue       = 1'b1;
          end
          TEST_DEVICE: begin
            offset_next = '0;
            if (region_size == '0) begin
              done = 1'b1;
            end else begin
              phase_next = PH_V_WR1;
              issue      = 1'b1;
            end
          end
          default: done = 1'b1;
        endcase
      end
    end else if (rsp_ok) begin
      issue = 1'b1;
      unique case (phase)
        PH_D_WR: phase_next = PH_D_RD;
        PH_D_RD: begin
          if (read_data != pattern_reg) begin
            fail     = 1'b1;
            fail_pat = 1'b1;
          end else begin
            pattern_next = {pattern_reg[6:0], 1'b0};
            if (pattern_reg[7]) done = 1'b1;
            else phase_next = PH_D_WR;
          end
        end
        PH_A_FILL: begin
          offset_next = dbl(offset_reg);
          if ((offset_next & mask) == '0) phase_next = PH_A_BASE55;
        end
        PH_A_BASE55: begin
          offset_next = {{(OFF_W-1){1'b0}}, 1'b1};
          phase_next  = mask[0] ? PH_A_HIGH : PH_A_BASEAA;
        end
        PH_A_HIGH: begin
          if (read_data != PAT_A) begin
            fail     = 1'b1;
            fail_off = offset_reg;
          end else begin
            offset_next = dbl(offset_reg);
            if ((offset_next & mask) == '0) phase_next = PH_A_BASEAA;
          end
        end
        PH_A_BASEAA: begin
          probe_next = {{(OFF_W-1){1'b0}}, 1'b1};
          if (!mask[0]) done = 1'b1;
          else phase_next = PH_A_T55;
        end
        PH_A_T55: phase_next = PH_A_TBASE;
        PH_A_TBASE: begin
          if (read_data != PAT_A) begin
            fail     = 1'b1;
            fail_off = probe_offset;
          end else begin
            offset_next = {{(OFF_W-1){1'b0}}, 1'b1};
            phase_next  = mask[0] ? PH_A_TRD : PH_A_TAA;
          end
        end
        PH_A_TRD: begin
          if ((read_data != PAT_A) && (offset_reg != probe_offset)) begin
            fail     = 1'b1;
            fail_off = probe_offset;
          end else begin
            offset_next = dbl(offset_reg);
            if ((offset_next & mask) == '0) phase_next = PH_A_TAA;
          end
        end
        PH_A_TAA: begin
          probe_next = dbl(probe_offset);
          if ((probe_next & mask) == '0) done = 1'b1;
          else phase_next = PH_A_T55;
        end
        PH_V_WR1, PH_V_WR2: begin
          offset_next = dev_more ? offset_inc : '0;
          if (!dev_more) phase_next = (phase == PH_V_WR1) ? PH_V_RD1 : PH_V_RD2;
        end
        PH_V_RD1, PH_V_RD2: begin
          if (read_data != ((phase == PH_V_RD1) ? pv_old : ~pv_old)) begin
            fail     = 1'b1;
            fail_off = offset_reg;
          end else if (dev_more) begin
            offset_next = offset_inc;
          end else if (phase == PH_V_RD1) begin
            offset_next = '0;
            phase_next  = PH_V_WR2;
          end else begin
            offset_next = offset_inc;
            done        = 1'b1;
          end
        end
        default: begin
          issue = 1'b0;
          phase_next = PH_IDLE;
        end
      endcase
      if (fail) done = 1'b1;
    end
    if (done) begin
      issue      = 1'b0;
      phase_next = PH_IDLE;
    end
  end

  // outputs
  assign pv_new = offset_next[7:0] + 8'd1;

  always_comb begin
    emit   = issue || done;
    result = '0;
    unique case (phase_next)
      PH_A_FILL, PH_A_HIGH, PH_A_TRD,
      PH_V_WR1, PH_V_RD1, PH_V_WR2, PH_V_RD2: req_off = offset_next;
      PH_A_T55, PH_A_TAA: req_off = probe_next;
      default: req_off = '0;
    endcase
    if (done) begin
      result.request_kind = REQ_DONE;
      result.failed       = fail;
      if (fail) result.fail_info = fail_pat ? {8'd0, pattern_reg}
                                            : addr_of(base_address, fail_off, AMASK);
    end else begin
      result.request_kind   = is_read_phase(phase_next) ? REQ_READ : REQ_WRITE;
      result.access_address = addr_of(base_address, req_off, AMASK);
      unique case (phase_next)
        PH_D_WR: result.write_data = pattern_next;
        PH_A_FILL, PH_A_BASEAA, PH_A_TAA: result.write_data = PAT_A;
        PH_A_BASE55, PH_A_T55: result.write_data = PAT_5;
        PH_V_WR1: result.write_data = pv_new;
        PH_V_WR2: result.write_data = ~pv_new;
        default: result.write_data = '0;
      endcase
    end
  end

endmodule

// File: sv/mst_out_buf.sv
// Output register for request words; frees itself as the receiver takes a word.
// Uses mst_pkg and mst_req_if.
module mst_out_buf
  import mst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     result,
  output logic        can_load,
  mst_req_if.source   req
);

  logic    valid;
  result_t word;

  assign can_load = !valid || req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      word <= result;
    end
  end

  assign req.valid          = valid;
  assign req.request_kind   = word.request_kind;
  assign req.access_address = word.access_address;
  assign req.write_data     = word.write_data;
  assign req.failed         = word.failed;
  assign req.fail_info      = word.fail_info;

endmodule
